[rtl/gei_pkg.sv]
package gei_pkg;

   // request kinds
   localparam logic [1:0] REQ_READ  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_EVENT = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   // register map
   localparam logic [3:0] ADDR_DIR     = 4'd0;
   localparam logic [3:0] ADDR_PIN     = 4'd1;
   localparam logic [3:0] ADDR_SET     = 4'd2;
   localparam logic [3:0] ADDR_CLR     = 4'd3;
   localparam logic [3:0] ADDR_EN_RISE = 4'd4;
   localparam logic [3:0] ADDR_EN_FALL = 4'd5;
   localparam logic [3:0] ADDR_ST_RISE = 4'd6;
   localparam logic [3:0] ADDR_ST_FALL = 4'd7;
   localparam logic [3:0] ADDR_INT_CLR = 4'd8;
   localparam logic [3:0] ADDR_PENDING = 4'd9;

   // result status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_PIN   = 2'd1;
   localparam logic [1:0] STAT_BAD_EVENT = 2'd2;
   localparam logic [1:0] STAT_BAD_ADDR  = 2'd3;

   // event kinds above this are rejected
   localparam logic [2:0] EVENT_MAX = 3'd3;

   // configuration register indexes
   localparam logic [0:0] CSR_VALID_MASK = 1'd0;

   // pins 0..30 except 12, 13 and 14
   localparam logic [31:0] VALID_MASK_RESET = 32'h7FFF_8FFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  addr;
      logic [31:0] data;
      logic [4:0]  pin;
      logic [2:0]  event_kind;
      logic [31:0] levels;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status_code;
      logic        irq;
   } result_type;

endpackage

[rtl/gpio_edge_interrupt_port.sv]
// A request beat held in the request register moves into the result register once
// the result side is free; a stalled result beat holds it back.
// Throughput: one request per cycle unless the result side stalls. The two registers
// form a two-stage pipe, so one request is still taken while a result waits.
// Reset (synchronous, active high): all port state clears to zero, the valid
// pin mask returns to 0x7FFF8FFF, and both pipe stages empty.
module gpio_edge_interrupt_port #(
   parameter int PIN_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_reg_addr,
   input  logic [31:0] req_write_data,
   input  logic [4:0]  req_pin_index,
   input  logic [2:0]  req_event_kind,
   input  logic [31:0] req_pin_levels,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_status_code,
   output logic        rsp_irq,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                item_valid_ff;
   gei_pkg::item_type   item_ff;
   logic                rsp_valid_ff;
   gei_pkg::result_type rsp_ff;
   gei_pkg::result_type result;
   logic [31:0]         valid_mask;
   logic                out_free;
   logic                fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.kind       <= req_type;
         item_ff.addr       <= req_reg_addr;
         item_ff.data       <= req_write_data;
         item_ff.pin        <= req_pin_index;
         item_ff.event_kind <= req_event_kind;
         item_ff.levels     <= req_pin_levels;
      end
   end

   gei_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .valid_mask (valid_mask)
   );

   gei_core #(
      .PIN_COUNT (PIN_COUNT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .valid_mask (valid_mask),
      .result     (result)
   );

   // hold the result beat while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_ff.read_data;
   assign rsp_status_code = rsp_ff.status_code;
   assign rsp_irq         = rsp_ff.irq;

endmodule

[rtl/gei_csr.sv]
module gei_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] valid_mask
);

   logic [31:0] valid_mask_ff;
   logic [31:0] valid_mask_in;
   logic        hit;

   assign pready = 1'b1;
   assign hit    = (paddr[2] == gei_pkg::CSR_VALID_MASK) && (paddr[1:0] == 2'b00);

   always_comb begin
      valid_mask_in = valid_mask_ff;
      if (psel && penable && pwrite && pready && hit) begin
         valid_mask_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mask_ff <= gei_pkg::VALID_MASK_RESET;
      end else begin
         valid_mask_ff <= valid_mask_in;
      end
   end

   assign prdata     = hit ? valid_mask_ff : 32'd0;
   assign valid_mask = valid_mask_ff;

endmodule

[rtl/gei_core.sv]
module gei_core #(
   parameter int PIN_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  gei_pkg::item_type    item,
   input  logic [31:0]          valid_mask,
   output gei_pkg::result_type  result
);

   localparam logic [31:0] PORT_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);

   logic [31:0] dir_ff, dir_in;
   logic [31:0] latch_ff, latch_in;
   logic [31:0] en_rise_ff, en_rise_in;
   logic [31:0] en_fall_ff, en_fall_in;
   logic [31:0] st_rise_ff, st_rise_in;
   logic [31:0] st_fall_ff, st_fall_in;
   logic [31:0] prev_ff, prev_in;

   logic [31:0] usable;
   logic [31:0] data;
   logic [31:0] levels;
   logic [31:0] pin_bit;
   logic [31:0] rdata;
   logic [1:0]  code;

   assign usable  = valid_mask & PORT_MASK;
   assign data    = item.data & PORT_MASK;
   assign levels  = item.levels & PORT_MASK;
   assign pin_bit = 32'd1 << item.pin;

   always_comb begin
      dir_in     = dir_ff;
      latch_in   = latch_ff;
      en_rise_in = en_rise_ff;
      en_fall_in = en_fall_ff;
      st_rise_in = st_rise_ff;
      st_fall_in = st_fall_ff;
      prev_in    = prev_ff;
      rdata      = 32'd0;
      code       = gei_pkg::STAT_OK;
      case (item.kind)
         gei_pkg::REQ_READ: begin
            case (item.addr)
               gei_pkg::ADDR_DIR:     rdata = dir_ff;
               gei_pkg::ADDR_PIN:     rdata = (latch_ff & dir_ff) | (prev_ff & ~dir_ff);
               gei_pkg::ADDR_SET:     rdata = latch_ff;
               gei_pkg::ADDR_CLR:     rdata = 32'd0;
               gei_pkg::ADDR_EN_RISE: rdata = en_rise_ff;
               gei_pkg::ADDR_EN_FALL: rdata = en_fall_ff;
               gei_pkg::ADDR_ST_RISE: rdata = st_rise_ff;
               gei_pkg::ADDR_ST_FALL: rdata = st_fall_ff;
               gei_pkg::ADDR_INT_CLR: rdata = 32'd0;
               gei_pkg::ADDR_PENDING: rdata = st_rise_ff | st_fall_ff;
               default:               code  = gei_pkg::STAT_BAD_ADDR;
            endcase
            rdata = rdata & PORT_MASK;
         end
         gei_pkg::REQ_WRITE: begin
            case (item.addr)
               gei_pkg::ADDR_DIR:     dir_in     = data;
               gei_pkg::ADDR_PIN:     latch_in   = data;
               gei_pkg::ADDR_SET:     latch_in   = latch_ff | data;
               gei_pkg::ADDR_CLR:     latch_in   = latch_ff & ~data;
               gei_pkg::ADDR_EN_RISE: en_rise_in = data & usable;
               gei_pkg::ADDR_EN_FALL: en_fall_in = data & usable;
               gei_pkg::ADDR_ST_RISE,
               gei_pkg::ADDR_ST_FALL,
               gei_pkg::ADDR_PENDING: ;
               gei_pkg::ADDR_INT_CLR: begin
                  st_rise_in = st_rise_ff & ~data;
                  st_fall_in = st_fall_ff & ~data;
               end
               default:               code = gei_pkg::STAT_BAD_ADDR;
            endcase
         end
         gei_pkg::REQ_EVENT: begin
            if ((usable & pin_bit) == 32'd0) begin
               code = gei_pkg::STAT_BAD_PIN;
            end else if (item.event_kind > gei_pkg::EVENT_MAX) begin
               code = gei_pkg::STAT_BAD_EVENT;
            end else begin
               en_rise_in = item.event_kind[0] ? (en_rise_ff | pin_bit)
                                               : (en_rise_ff & ~pin_bit);
               en_fall_in = item.event_kind[1] ? (en_fall_ff | pin_bit)
                                               : (en_fall_ff & ~pin_bit);
            end
         end
         default: begin
            // sample tick: latch enabled edges on pins valid right now
            st_rise_in = st_rise_ff | (levels & ~prev_ff & en_rise_ff & usable);
            st_fall_in = st_fall_ff | (~levels & prev_ff & en_fall_ff & usable);
            prev_in    = levels;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= 32'd0;
         latch_ff   <= 32'd0;
         en_rise_ff <= 32'd0;
         en_fall_ff <= 32'd0;
         st_rise_ff <= 32'd0;
         st_fall_ff <= 32'd0;
         prev_ff    <= 32'd0;
      end else if (fire) begin
         dir_ff     <= dir_in;
         latch_ff   <= latch_in;
         en_rise_ff <= en_rise_in;
         en_fall_ff <= en_fall_in;
         st_rise_ff <= st_rise_in;
         st_fall_ff <= st_fall_in;
         prev_ff    <= prev_in;
      end
   end

   assign result.read_data   = rdata;
   assign result.status_code = code;
   assign result.irq         = ((st_rise_in | st_fall_in) != 32'd0);

endmodule

[rtl/gei_checker.sv]
module gei_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data,
   input logic [1:0]  rsp_status_code,
   input logic        rsp_irq
);

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // request side only backs up when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result beat");

   // a bad register address never returns data
   a_bad_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status_code == gei_pkg::STAT_BAD_ADDR)) |-> (rsp_read_data == 32'd0))
      else $error("bad address returned nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_status_code) && $stable(rsp_irq)))
      else $error("stalled result beat changed");

endmodule

bind gpio_edge_interrupt_port gei_checker u_gei_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_read_data   (rsp_read_data),
   .rsp_status_code (rsp_status_code),
   .rsp_irq         (rsp_irq)
);

[tb/gpio_edge_interrupt_port_test.sv]
module gpio_edge_interrupt_port_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MASK_PADDR = {gei_pkg::CSR_VALID_MASK, 2'b00};
   localparam logic [3:0] ADDR_FIRST_UNMAPPED = 4'd10;
   localparam logic [3:0] ADDR_TOP = 4'd15;
   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_RISE = 3'd1;
   localparam logic [2:0] EV_FALL = 3'd2;
   localparam logic [2:0] EV_BOTH = 3'd3;
   localparam logic [2:0] EV_TOP = 3'd7;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int LONG_HOLD = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [3:0]  req_reg_addr = '0;
   logic [31:0] req_write_data = '0;
   logic [4:0]  req_pin_index = '0;
   logic [2:0]  req_event_kind = '0;
   logic [31:0] req_pin_levels = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic [1:0]  rsp_status_code;
   logic        rsp_irq;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gpio_edge_interrupt_port u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_reg_addr(req_reg_addr), .req_write_data(req_write_data),
      .req_pin_index(req_pin_index), .req_event_kind(req_event_kind),
      .req_pin_levels(req_pin_levels),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_data(rsp_read_data),
      .rsp_status_code(rsp_status_code), .rsp_irq(rsp_irq),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // port state as the block should hold it
   logic [31:0] pin_valid_mask = gei_pkg::VALID_MASK_RESET;
   logic [31:0] dir_bits = '0;
   logic [31:0] out_latch = '0;
   logic [31:0] rise_en = '0;
   logic [31:0] fall_en = '0;
   logic [31:0] rise_pend = '0;
   logic [31:0] fall_pend = '0;
   logic [31:0] last_levels = '0;

   gei_pkg::item_type   pending_requests[$];
   gei_pkg::result_type expected_results[$];
   gei_pkg::item_type   offered;
   logic [31:0] stim_levels = '0;

   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned stall_left = 0;
   int unsigned recv_calm = 0;
   bit long_hold_go = 1'b0;
   bit long_hold_done = 1'b0;
   int result_errors = 0;
   int csr_errors = 0;

   function automatic gei_pkg::result_type gpio_apply(input gei_pkg::item_type it);
      gei_pkg::result_type r;
      logic [31:0] usable;
      r = '0;
      usable = pin_valid_mask;
      case (it.kind)
         gei_pkg::REQ_READ: begin
            case (it.addr)
               gei_pkg::ADDR_DIR:     r.read_data = dir_bits;
               gei_pkg::ADDR_PIN:     r.read_data = (out_latch & dir_bits)
                                                    | (last_levels & ~dir_bits);
               gei_pkg::ADDR_SET:     r.read_data = out_latch;
               gei_pkg::ADDR_CLR,
               gei_pkg::ADDR_INT_CLR: r.read_data = '0;
               gei_pkg::ADDR_EN_RISE: r.read_data = rise_en;
               gei_pkg::ADDR_EN_FALL: r.read_data = fall_en;
               gei_pkg::ADDR_ST_RISE: r.read_data = rise_pend;
               gei_pkg::ADDR_ST_FALL: r.read_data = fall_pend;
               gei_pkg::ADDR_PENDING: r.read_data = rise_pend | fall_pend;
               default:               r.status_code = gei_pkg::STAT_BAD_ADDR;
            endcase
         end
         gei_pkg::REQ_WRITE: begin
            case (it.addr)
               gei_pkg::ADDR_DIR:     dir_bits = it.data;
               gei_pkg::ADDR_PIN:     out_latch = it.data;
               gei_pkg::ADDR_SET:     out_latch = out_latch | it.data;
               gei_pkg::ADDR_CLR:     out_latch = out_latch & ~it.data;
               gei_pkg::ADDR_EN_RISE: rise_en = it.data & usable;
               gei_pkg::ADDR_EN_FALL: fall_en = it.data & usable;
               gei_pkg::ADDR_ST_RISE, gei_pkg::ADDR_ST_FALL, gei_pkg::ADDR_PENDING: ;
               gei_pkg::ADDR_INT_CLR: begin
                  rise_pend = rise_pend & ~it.data;
                  fall_pend = fall_pend & ~it.data;
               end
               default:               r.status_code = gei_pkg::STAT_BAD_ADDR;
            endcase
         end
         gei_pkg::REQ_EVENT: begin
            if (!usable[it.pin]) begin
               r.status_code = gei_pkg::STAT_BAD_PIN;
            end else if (it.event_kind > gei_pkg::EVENT_MAX) begin
               r.status_code = gei_pkg::STAT_BAD_EVENT;
            end else begin
               rise_en[it.pin] = it.event_kind[0];
               fall_en[it.pin] = it.event_kind[1];
            end
         end
         default: begin
            rise_pend = rise_pend | (it.levels & ~last_levels & rise_en & usable);
            fall_pend = fall_pend | (~it.levels & last_levels & fall_en & usable);
            last_levels = it.levels;
         end
      endcase
      r.irq = |(rise_pend | fall_pend);
      return r;
   endfunction

   function automatic gei_pkg::item_type make_item(input logic [1:0] kind,
                                                   input logic [3:0] addr,
                                                   input logic [31:0] data,
                                                   input logic [4:0] pin,
                                                   input logic [2:0] ev,
                                                   input logic [31:0] levels);
      gei_pkg::item_type it;
      it.kind = kind;
      it.addr = addr;
      it.data = data;
      it.pin = pin;
      it.event_kind = ev;
      it.levels = levels;
      return it;
   endfunction

   function automatic gei_pkg::item_type random_request();
      gei_pkg::item_type it;
      int unsigned roll;
      it.addr = 4'($urandom_range(9));
      if ($urandom_range(9) == 0) it.addr = 4'($urandom_range(15, 10));
      it.data = $urandom;
      roll = $urandom_range(9);
      if (roll == 0) it.data = '1;
      if (roll == 1) it.data = '0;
      it.pin = 5'($urandom);
      it.event_kind = 3'($urandom_range(3));
      if ($urandom_range(6) == 0) it.event_kind = 3'($urandom_range(7, 4));
      // walk the pin levels: mostly a few toggles, sometimes a fresh word
      roll = $urandom_range(9);
      if (roll < 4) stim_levels[5'($urandom_range(31))] ^= 1'b1;
      else if (roll < 8) stim_levels = stim_levels ^ ($urandom & $urandom);
      else if (roll < 9) stim_levels = $urandom;
      it.levels = stim_levels;
      roll = $urandom_range(99);
      if (roll < 20) it.kind = gei_pkg::REQ_READ;
      else if (roll < 45) it.kind = gei_pkg::REQ_WRITE;
      else if (roll < 65) it.kind = gei_pkg::REQ_EVENT;
      else it.kind = gei_pkg::REQ_TICK;
      return it;
   endfunction

   function automatic int unsigned idle_length(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         calm = $urandom_range(60, 20);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // request driver: hold a beat until taken, then idle a while
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(gpio_apply(offered));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               offered = pending_requests.pop_front();
               req_type <= offered.kind;
               req_reg_addr <= offered.addr;
               req_write_data <= offered.data;
               req_pin_index <= offered.pin;
               req_event_kind <= offered.event_kind;
               req_pin_levels <= offered.levels;
               req_valid <= 1'b1;
               send_gap = idle_length(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         long_hold_done = 1'b1;
         stall_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_length(recv_calm);
      end
   end

   always @(posedge clock) begin
      gei_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: read_data %h status %0d irq %0d",
                   rsp_read_data, rsp_status_code, rsp_irq);
            result_errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               result_errors++;
            end
            if (rsp_status_code !== want.status_code) begin
               $error("status_code: expected %0d, got %0d", want.status_code, rsp_status_code);
               result_errors++;
            end
            if (rsp_irq !== want.irq) begin
               $error("irq: expected %0d, got %0d", want.irq, rsp_irq);
               result_errors++;
            end
         end
      end
   end

   task automatic csr_access(input bit is_write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= MASK_PADDR;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (is_write) pin_valid_mask = wdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_valid_mask(input logic [31:0] value);
      logic [31:0] readback;
      csr_access(1'b1, value, readback);
      csr_access(1'b0, '0, readback);
      if (readback !== value) begin
         $error("valid_pin_mask: expected %h, got %h", value, readback);
         csr_errors++;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [31:0] masks[5];
      masks = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom,
                gei_pkg::VALID_MASK_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed pass under the reset mask
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_EN_RISE,
                                           '1, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_EN_FALL,
                                           '1, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_EN_RISE,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, ADDR_TOP,
                                           '0, 5'd12, EV_RISE, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, '0, '0, 5'd31, EV_BOTH, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, '0, '0, 5'd0, EV_TOP, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, '0, '0, 5'd5, EV_NONE, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, '0, '0, 5'd3, EV_FALL, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_EVENT, '0, '0, 5'd4, EV_RISE, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_TICK, ADDR_TOP, '1, '0, '0, '1));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_PENDING,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_TICK, '0, '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_ST_RISE,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_ST_FALL,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_INT_CLR,
                                           '1, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_DIR,
                                           32'hA5A5_5A5A, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_PIN,
                                           32'hFFFF_0000, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_SET,
                                           32'h0000_00FF, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_CLR,
                                           32'h0F00_000F, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_PIN,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_SET,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_CLR,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, gei_pkg::ADDR_INT_CLR,
                                           '0, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, gei_pkg::ADDR_ST_RISE,
                                           '1, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_WRITE, ADDR_FIRST_UNMAPPED,
                                           '1, '0, '0, '0));
      pending_requests.push_back(make_item(gei_pkg::REQ_READ, ADDR_TOP, '1, '0, '0, '0));
      wait_drained();

      foreach (masks[i]) begin
         program_valid_mask(masks[i]);
         // fill the pipe against a stalled receiver once
         if (i == 1) long_hold_go = 1'b1;
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (result_errors + csr_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[gpio_edge_interrupt_port.f]
rtl/gei_pkg.sv
rtl/gei_csr.sv
rtl/gei_core.sv
rtl/gpio_edge_interrupt_port.sv
rtl/gei_checker.sv
tb/gpio_edge_interrupt_port_test.sv
